// File: rtl/ctc_greedy_text_decoder_unit_defines.svh
// assertion macros for the ctc greedy text decoder
// used by modules that check their own control logic
`ifndef CTC_GREEDY_TEXT_DECODER_UNIT_DEFINES_SVH
`define CTC_GREEDY_TEXT_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define CTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ctc check failed");

// next-cycle implication
`define CTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctc check failed");

`endif

// File: rtl/ctc_pkg.sv
// types, constants and exp tables for the ctc greedy text decoder
// no dependencies
`timescale 1ns / 1ps

package ctc_pkg;

    localparam logic [23:0] SUM_MAX = 24'hFF_FFFF;
    localparam logic [23:0] ONE_Q16 = 24'h01_0000;
    localparam logic [7:0]  PREV_NONE = 8'd255;
    localparam logic [6:0]  SYMBOL_COUNT = 7'd96;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               row_end;
        logic               seq_end;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [6:0]  char_code;
        logic [15:0] prob;
        logic [7:0]  char_count;
        logic [15:0] confidence;
        logic        last;
    } t_res;

    // classified item handed from front to core
    typedef struct packed {
        logic signed [15:0] logit;
        logic               row_done;
        logic               seq_done;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [23:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } t_div_rsp;

    typedef logic [255:0][16:0] t_frac_tab;

    function automatic logic [16:0] exp_frac(input int f);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = 64'(f) << 24;
        term = 64'd1 << 32;
        sum  = term;
        for (int i = 1; i <= 9; i++) begin
            term = ((term * x) >> 32) / 64'(i);
            if ((i % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 17'((sum + 64'd32768) >> 16);
    endfunction

    function automatic t_frac_tab build_frac_tab();
        t_frac_tab t;
        for (int f = 0; f < 256; f++) begin
            t[f] = exp_frac(f);
        end
        return t;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();

    function automatic logic [16:0] exp_int(input logic [7:0] n);
        logic [16:0] r;
        case (n)
            8'd0:    r = 17'd65536;
            8'd1:    r = 17'd24109;
            8'd2:    r = 17'd8869;
            8'd3:    r = 17'd3263;
            8'd4:    r = 17'd1200;
            8'd5:    r = 17'd442;
            8'd6:    r = 17'd162;
            8'd7:    r = 17'd60;
            8'd8:    r = 17'd22;
            8'd9:    r = 17'd8;
            8'd10:   r = 17'd3;
            8'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // digits, space and letters of the symbol set
    function automatic logic is_wanted(input logic [6:0] k);
        return (k >= 7'd1 && k <= 7'd10) || (k >= 7'd44 && k <= 7'd96);
    endfunction

    function automatic logic [6:0] char_of(input logic [6:0] k);
        logic [6:0] c;
        if (k <= 7'd10) begin
            c = k + 7'd47;
        end else if (k == 7'd44) begin
            c = 7'd32;
        end else if (k <= 7'd70) begin
            c = k + 7'd20;
        end else begin
            c = k + 7'd26;
        end
        return c;
    endfunction

endpackage

// File: rtl/ctc_front.sv
// front queue: accepts score items and classifies their row and sequence marks
// depends on ctc_pkg
`timescale 1ns / 1ps

module ctc_front import ctc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_in   i_in,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    t_item       r_mem [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic        wr;
    logic        rd;

    assign full    = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign wr      = push && !full;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= '{logit: i_in.logit,
                             row_done: i_in.row_end || i_in.seq_end,
                             seq_done: i_in.seq_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end

endmodule

// File: rtl/ctc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ctc_pkg
`timescale 1ns / 1ps

module ctc_div import ctc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [24:0] r_rem;
    logic [32:0] r_quo;
    logic [23:0] r_den;
    logic [24:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[23:0], r_quo[32]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign o_rsp  = '{done: r_done, quo: r_quo};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_quo <= {r_quo[31:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/ctc_res_fifo.sv
// result queue between the core and the result ports
// depends on ctc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ctc_greedy_text_decoder_unit_defines.svh"

module ctc_res_fifo import ctc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_full,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    t_res       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_res  = r_mem[r_rp];
    assign rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(rd);
        end
    end

    `CTC_ASSERT_NOW(a_no_overflow, i_wr, !o_full || rd)
    `CTC_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= 2'd2)
    `CTC_ASSERT_NEXT(a_drain, rd && !i_wr, r_cnt == $past(r_cnt) - 2'd1)

endmodule

// File: rtl/ctc_core.sv
// back end: online softmax per row, greedy collapse, emission and summary
// depends on ctc_pkg and uses the shared divider through request structs
`timescale 1ns / 1ps

module ctc_core import ctc_pkg::*; #(
    parameter int ALPHABET_SIZE = 96,
    parameter int MAX_CLASSES   = 128,
    parameter int MAX_STEPS     = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic     [15:0] i_cfg_data,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_take,
    output t_div_req o_div,
    input  t_div_rsp i_div,
    output logic     o_wr,
    output t_res     o_res,
    input  logic     i_full
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_EXP, S_EXP2, S_SCALE, S_SCALE2,
        S_END, S_DIVP, S_EMIT, S_SEQ, S_DIVC, S_SUM
    } t_state;

    t_state             r_state;
    logic [15:0]        r_thr;
    logic signed [15:0] r_v;
    logic               r_row;
    logic               r_seq;
    logic signed [15:0] r_max;
    logic [6:0]         r_arg;
    logic [7:0]         r_ci;
    logic [23:0]        r_sum;
    logic [7:0]         r_prev;
    logic [23:0]        r_total;
    logic [7:0]         r_count;
    logic [8:0]         r_step;
    logic               r_gt;
    logic [7:0]         r_dn;
    logic [7:0]         r_df;
    logic [33:0]        r_prod;
    logic [16:0]        r_e;
    logic [40:0]        r_prod2;
    logic [15:0]        r_p;
    logic               r_emit;
    logic [15:0]        r_conf;
    logic               r_take;
    logic               r_wr;
    t_res               r_res;
    t_div_req           r_div;

    logic               gt;
    logic [16:0]        diff;
    logic [33:0]        e_rnd;
    logic [24:0]        sum_add;
    logic [41:0]        sc_rnd;
    logic [26:0]        sc_sum;
    logic [15:0]        p_sat;
    logic               emit_ok;
    logic [7:0]         cnt_new;

    assign gt      = r_v > r_max;
    assign diff    = gt ? {r_v[15], r_v} - {r_max[15], r_max}
                        : {r_max[15], r_max} - {r_v[15], r_v};
    assign e_rnd   = r_prod + 34'd32768;
    assign sum_add = {1'b0, r_sum} + {8'd0, r_e};
    assign sc_rnd  = {1'b0, r_prod2} + 42'd32768;
    assign sc_sum  = {1'b0, sc_rnd[41:16]} + {3'd0, ONE_Q16};
    assign p_sat   = (i_div.quo[32:16] != '0) ? 16'hFFFF : i_div.quo[15:0];
    assign emit_ok = (r_arg != 7'd0) && ({1'b0, r_arg} != r_prev)
                     && (r_arg <= 7'(ALPHABET_SIZE)) && (r_arg <= SYMBOL_COUNT)
                     && is_wanted(r_arg) && (p_sat > r_thr);
    assign cnt_new = (r_count != 8'd255) ? r_count + 8'd1 : r_count;

    assign o_take = r_take;
    assign o_wr   = r_wr;
    assign o_res  = r_res;
    assign o_div  = r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= 16'd58982;
            r_max   <= 16'sh8000;
            r_arg   <= '0;
            r_ci    <= '0;
            r_sum   <= '0;
            r_prev  <= PREV_NONE;
            r_total <= '0;
            r_count <= '0;
            r_step  <= '0;
            r_take  <= 1'b0;
            r_wr    <= 1'b0;
            r_div   <= '0;
        end else begin
            r_take      <= 1'b0;
            r_wr        <= 1'b0;
            r_div.start <= 1'b0;
            if (i_cfg_valid) r_thr <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_take) begin
                        r_v     <= i_item.logit;
                        r_row   <= i_item.row_done;
                        r_seq   <= i_item.seq_done;
                        r_take  <= 1'b1;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (r_ci >= 8'(MAX_CLASSES)) begin
                        r_state <= S_END;
                    end else if (r_ci == 8'd0) begin
                        r_max   <= r_v;
                        r_arg   <= '0;
                        r_sum   <= ONE_Q16;
                        r_ci    <= r_ci + 8'd1;
                        r_state <= S_END;
                    end else begin
                        r_gt    <= gt;
                        r_dn    <= diff[15:8];
                        r_df    <= diff[7:0];
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    r_prod  <= exp_int(r_dn) * FRAC_TAB[r_df];
                    r_state <= S_EXP2;
                end
                S_EXP2: begin
                    r_e <= e_rnd[32:16];
                    if (r_gt) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_SCALE2;
                    end
                end
                S_SCALE: begin
                    r_prod2 <= r_sum * r_e;
                    r_state <= S_SCALE2;
                end
                S_SCALE2: begin
                    if (r_gt) begin
                        r_sum <= (sc_sum > {3'd0, SUM_MAX}) ? SUM_MAX : sc_sum[23:0];
                        r_max <= r_v;
                        r_arg <= r_ci[6:0];
                    end else begin
                        r_sum <= sum_add[24] ? SUM_MAX : sum_add[23:0];
                    end
                    r_ci    <= r_ci + 8'd1;
                    r_state <= S_END;
                end
                S_END: begin
                    if (!r_row) begin
                        r_state <= S_IDLE;
                    end else if (r_step < 9'(MAX_STEPS)) begin
                        r_div.start <= 1'b1;
                        r_div.den   <= (r_sum != '0) ? r_sum : 24'd1;
                        r_div.num   <= {1'b1, 32'd0}
                                       + {10'd0, ((r_sum != '0) ? r_sum[23:1] : 23'd0)};
                        r_state     <= S_DIVP;
                    end else begin
                        r_ci    <= '0;
                        r_max   <= 16'sh8000;
                        r_state <= S_SEQ;
                    end
                end
                S_DIVP: begin
                    if (i_div.done) begin
                        r_p     <= p_sat;
                        r_emit  <= emit_ok;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_emit || !i_full) begin
                        if (r_emit) begin
                            r_count <= cnt_new;
                            if (r_count != 8'd255) r_total <= r_total + {8'd0, r_p};
                            r_wr  <= 1'b1;
                            r_res <= '{kind: 1'b0, char_code: char_of(r_arg), prob: r_p,
                                       char_count: cnt_new, confidence: 16'd0,
                                       last: 1'b0};
                        end
                        r_prev  <= {1'b0, r_arg};
                        r_step  <= r_step + 9'd1;
                        r_ci    <= '0;
                        r_max   <= 16'sh8000;
                        r_state <= S_SEQ;
                    end
                end
                S_SEQ: begin
                    if (!r_seq) begin
                        r_state <= S_IDLE;
                    end else if (r_count != 8'd0) begin
                        r_div.start <= 1'b1;
                        r_div.num   <= {9'd0, r_total};
                        r_div.den   <= {16'd0, r_count};
                        r_state     <= S_DIVC;
                    end else begin
                        r_conf  <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_DIVC: begin
                    if (i_div.done) begin
                        r_conf  <= i_div.quo[15:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!i_full && !r_wr) begin
                        r_wr    <= 1'b1;
                        r_res   <= '{kind: 1'b1, char_code: 7'd0, prob: 16'd0,
                                     char_count: r_count, confidence: r_conf, last: 1'b1};
                        r_prev  <= PREV_NONE;
                        r_total <= '0;
                        r_count <= '0;
                        r_step  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/ctc_greedy_text_decoder_unit.sv
// Greedy CTC text decoder. Scores enter one class per transfer through a four-deep
// front queue; the core takes one score at a time. A row's first class or a class past
// the bound passes only the class and end states, a score at or below the running max
// adds the exp table lookup and exp multiply, a new maximum also the rescale multiply.
// A row end within the step bound adds the 33-step serial divide that yields the top
// probability, a sequence end with characters the mean-confidence divide; both share one
// divider. Results leave through a two-deep queue. Threshold writes are taken any time.
// depends on ctc_pkg, ctc_front, ctc_core, ctc_div, ctc_res_fifo
`timescale 1ns / 1ps

module ctc_greedy_text_decoder_unit import ctc_pkg::*; #(
    parameter int ALPHABET_SIZE = 96,
    parameter int MAX_CLASSES   = 128,
    parameter int MAX_STEPS     = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_in,
    output logic        empty,
    input  logic        pop,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic     item_valid;
    t_item    item;
    logic     take;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     res_wr;
    t_res     res;
    logic     res_full;

    assign o_cfg_ready = 1'b1;

    ctc_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_in,
        .o_valid(item_valid), .o_item(item), .i_take(take)
    );

    ctc_core #(
        .ALPHABET_SIZE(ALPHABET_SIZE), .MAX_CLASSES(MAX_CLASSES), .MAX_STEPS(MAX_STEPS)
    ) u_core (
        .i_clk, .i_rst_n,
        .i_cfg_valid(i_cfg_valid && o_cfg_ready), .i_cfg_data,
        .i_valid(item_valid), .i_item(item), .o_take(take),
        .o_div(div_req), .i_div(div_rsp),
        .o_wr(res_wr), .o_res(res), .i_full(res_full)
    );

    ctc_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    ctc_res_fifo u_res (
        .i_clk, .i_rst_n, .i_wr(res_wr), .i_res(res), .o_full(res_full),
        .empty, .pop, .o_res
    );

endmodule
